>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_BACK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [CELL_W-1:0] RESET_BLANK = {BG_RESET, FG_RESET, CH_SPACE};

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        cursor_moved;
    logic [15:0] cell_data;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_RD_WAIT, ST_SCR_RD, ST_SCR_WR, ST_FILL, ST_DONE
  } tcw_state_t;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_HOME, CUR_CR, CUR_ADV, CUR_NEWLINE, CUR_BACK
  } cur_op_t;

  typedef enum logic [1:0] {WD_CHAR, WD_BLANK, WD_RESET, WD_COPY} wd_sel_t;
  typedef enum logic [1:0] {WA_CURSOR, WA_BACK, WA_CNT} wa_sel_t;
  typedef enum logic {RA_IDX, RA_COPY} ra_sel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_TAIL, CNT_INC} cnt_op_t;

  typedef struct packed {
    logic    load_item;
    cur_op_t cur_op;
    logic    mem_we;
    wd_sel_t wd_sel;
    wa_sel_t wa_sel;
    ra_sel_t ra_sel;
    cnt_op_t cnt_op;
    logic    set_moved;
    logic    cap_data;
    logic    out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_nl;
    logic       is_cr;
    logic       col_zero;
    logic       col_last;
    logic       row_last;
    logic       idx_ok;
    logic       cnt_copy_end;
    logic       cnt_end;
  } tcw_sts_t;

endpackage

>>> hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: decodes each item and walks the screen store for
// reset sweep, clear and scroll.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       scroll;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    scroll    = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = WD_RESET;
        cmd.wa_sel = WA_CNT;
        cmd.cnt_op = CNT_INC;
        if (sts.cnt_end) begin
          cmd.cnt_op = CNT_ZERO;
          state_nxt  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (sts.func)
          FUNC_PUT: begin
            cmd.set_moved = 1'b1;
            if (sts.is_nl) begin
              cmd.cur_op = CUR_NEWLINE;
              scroll     = sts.row_last;
            end else if (sts.is_cr) begin
              cmd.cur_op = CUR_CR;
            end else begin
              cmd.mem_we = 1'b1;
              cmd.wd_sel = WD_CHAR;
              cmd.wa_sel = WA_CURSOR;
              cmd.cur_op = CUR_ADV;
              scroll     = sts.col_last && sts.row_last;
            end
            if (scroll) begin
              cmd.cnt_op = CNT_ZERO;
              state_nxt  = ST_SCR_RD;
            end
          end
          FUNC_BACK: begin
            if (!sts.col_zero) begin
              cmd.mem_we    = 1'b1;
              cmd.wd_sel    = WD_BLANK;
              cmd.wa_sel    = WA_BACK;
              cmd.cur_op    = CUR_BACK;
              cmd.set_moved = 1'b1;
            end
          end
          FUNC_CLEAR: begin
            cmd.cur_op = CUR_HOME;
            cmd.cnt_op = CNT_ZERO;
            state_nxt  = ST_FILL;
          end
          FUNC_READ: begin
            cmd.ra_sel = RA_IDX;
            if (sts.idx_ok) begin
              state_nxt = ST_RD_WAIT;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_RD_WAIT: begin
        cmd.cap_data = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_SCR_RD: begin
        cmd.ra_sel = RA_COPY;
        state_nxt  = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = WD_COPY;
        cmd.wa_sel = WA_CNT;
        if (sts.cnt_copy_end) begin
          // copy done, blank the bottom row next
          cmd.cnt_op = CNT_TAIL;
          state_nxt  = ST_FILL;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_nxt  = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = WD_BLANK;
        cmd.wa_sel = WA_CNT;
        cmd.cnt_op = CNT_INC;
        if (sts.cnt_end) begin
          cmd.cnt_op = CNT_ZERO;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != ST_IDLE);

endmodule

>>> hdl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath of the console: cursor, color registers, sweep counter, screen
// store and result register.
// ----------------------------------------------------------------------------
module tcw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::tcw_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  tcw_pkg::tcw_cmd_t             cmd,
  output tcw_pkg::tcw_sts_t             sts,
  output tcw_pkg::tcw_out_t             out_data
);
  import tcw_pkg::*;

  tcw_in_t           item_r;
  logic [3:0]        fg_r, bg_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              moved_r;
  logic [CELL_W-1:0] data_r;
  tcw_out_t          out_r;

  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata, blank;
  logic [ROW_W-1:0]  row_step;
  logic              col_last, row_last;

  assign pos      = ADDR_W'(row_r * COLUMNS) + ADDR_W'(col_r);
  assign blank    = {bg_r, fg_r, CH_SPACE};
  assign col_last = (col_r == COL_W'(COLUMNS - 1));
  assign row_last = (row_r == ROW_W'(ROWS - 1));
  // past the bottom the row stays put; the scroll moves the text instead
  assign row_step = row_last ? row_r : row_r + ROW_W'(1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    case (cmd.cur_op)
      CUR_HOME: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      CUR_CR: col_nxt = '0;
      CUR_ADV: begin
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_step;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      CUR_NEWLINE: begin
        col_nxt = '0;
        row_nxt = row_step;
      end
      CUR_BACK: col_nxt = col_r - COL_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_ZERO: cnt_nxt = '0;
      CNT_TAIL: cnt_nxt = ADDR_W'(CELL_COUNT - COLUMNS);
      CNT_INC:  cnt_nxt = cnt_r + ADDR_W'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r  <= FG_RESET;
      bg_r  <= BG_RESET;
      row_r <= '0;
      col_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FG: fg_r <= cfg_data;
          CFG_BG: bg_r <= cfg_data;
          default: ;
        endcase
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r  <= in_data;
      moved_r <= 1'b0;
      data_r  <= '0;
    end else begin
      if (cmd.set_moved) begin
        moved_r <= 1'b1;
      end
      if (cmd.cap_data) begin
        data_r <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_r.cursor_pos   <= 11'(pos);
      out_r.cursor_moved <= moved_r;
      out_r.cell_data    <= data_r;
    end
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_CHAR:  wdata = {bg_r, fg_r, item_r.char_code};
      WD_BLANK: wdata = blank;
      WD_RESET: wdata = RESET_BLANK;
      default:  wdata = rdata;
    endcase
  end

  always_comb begin
    case (cmd.wa_sel)
      WA_CURSOR: waddr = pos;
      WA_BACK:   waddr = pos - ADDR_W'(1);
      default:   waddr = cnt_r;
    endcase
  end

  assign raddr = (cmd.ra_sel == RA_COPY) ? cnt_r + ADDR_W'(COLUMNS)
                                         : ADDR_W'(item_r.cell_index);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.func         = item_r.func;
  assign sts.is_nl        = (item_r.char_code == CH_NL);
  assign sts.is_cr        = (item_r.char_code == CH_CR);
  assign sts.col_zero     = (col_r == '0);
  assign sts.col_last     = col_last;
  assign sts.row_last     = row_last;
  assign sts.idx_ok       = (32'(item_r.cell_index) < CELL_COUNT);
  assign sts.cnt_copy_end = (cnt_r == ADDR_W'(CELL_COUNT - COLUMNS - 1));
  assign sts.cnt_end      = (cnt_r == ADDR_W'(CELL_COUNT - 1));

  assign out_data = out_r;

endmodule

>>> hdl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine over a screen store of 16-bit character cells.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   tcw_in_t  (func, char, cell index)
//   out      output     out_valid/out_stall tcw_out_t (cursor, moved, cell)
//   cfg      input      cfg_we              cfg_index, cfg_data (colors)
//
// Put, backspace and out-of-range read go through ST_EXEC and ST_DONE; an in-range read
// adds ST_RD_WAIT. A scroll reads and then writes each moved cell in turn (ST_SCR_RD,
// ST_SCR_WR), then blanks the bottom row. Clear makes one store write per cell.
// After reset a sweep blanks the store; in_stall is high.
// A result waits in ST_DONE for a free output register; only then is the next item taken.
// ----------------------------------------------------------------------------
module text_console_writer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tcw_pkg::tcw_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcw_pkg::tcw_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // the store is never written while the block waits for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cmd.mem_we)
    else $error("screen store written while idle");

  // a held result beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled beat");

  // an accepted item keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // reset starts the blanking sweep
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");
`endif

endmodule
